// ===== hdl/dds_pkg.sv =====
// Package for the decimal digit square root core: fixed field widths and the
// capped power-of-ten table that feeds the digit search.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dds_pkg;

  // Field widths of the item and result channels.
  localparam int unsigned RAD_W  = 54;
  localparam int unsigned ROOT_W = 27;

  // A digit weight of 2^28 or more squares past any 54-bit remainder.
  localparam int unsigned TERM_W = 28;
  // Weights are held capped at 2^28, so they need one bit more than a term.
  localparam int unsigned WGT_W  = TERM_W + 1;
  // Running multiple of the weight; nine times the cap still fits.
  localparam int unsigned TACC_W = 32;
  // Index width of the power-of-ten table (positions 0 to 16).
  localparam int unsigned POW_IDX_W = 5;
  // (2*root + t) is below 2^29 and t below 2^28.
  localparam int unsigned SUM_W  = TERM_W + 1;
  localparam int unsigned PROD_W = SUM_W + TERM_W;

  localparam logic [WGT_W-1:0] WGT_CAP = WGT_W'(1) << TERM_W;
  localparam logic [3:0]       DIGIT_MAX = 4'd9;

  // Power of ten for a root digit position, capped at 2^28.
  function automatic logic [WGT_W-1:0] pow10_cap(input logic [POW_IDX_W-1:0] idx);
    logic [WGT_W-1:0] w;
    case (idx)
      5'd0:    w = WGT_W'(1);
      5'd1:    w = WGT_W'(10);
      5'd2:    w = WGT_W'(100);
      5'd3:    w = WGT_W'(1000);
      5'd4:    w = WGT_W'(10000);
      5'd5:    w = WGT_W'(100000);
      5'd6:    w = WGT_W'(1000000);
      5'd7:    w = WGT_W'(10000000);
      5'd8:    w = WGT_W'(100000000);
      default: w = WGT_CAP;
    endcase
    return w;
  endfunction

endpackage : dds_pkg

`default_nettype wire

// ===== hdl/decimal_digit_square_root_core.sv =====
// Decimal digit-by-digit square root core: sequencer, shared multiplier and
// compare, output register. Depends on dds_pkg.
//
//   channel | direction | ports                           | handshake
//   --------+-----------+---------------------------------+------------------
//   in      | input     | in_radicand[53:0]               | in_valid / in_stall
//   out     | output    | out_root[26:0], out_remainder   | out_valid / out_stall
//
// Each root digit tries d = 1, 2, ... through one multiplier, one trial issued
// per cycle with its compare in the cycle after, and stops at the first misfit;
// a nine ends the search with its last trial. An item computes
// N = INT_DIGITS + FRAC_DIGITS root digits.
// The input stalls from acceptance until the result moves into the output
// register; the output register holds a finished item while a new one runs.
// Reset is synchronous and active low and clears only control state.
`timescale 1ns / 1ps
`default_nettype none

module decimal_digit_square_root_core
  import dds_pkg::*;
#(
  parameter int unsigned INT_DIGITS  = 4,
  parameter int unsigned FRAC_DIGITS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [RAD_W-1:0]  in_radicand,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ROOT_W-1:0]      out_root,
  output logic [RAD_W-1:0]       out_remainder
);

  localparam int unsigned NUM_POS = INT_DIGITS + FRAC_DIGITS;
  localparam int unsigned POS_W   = (NUM_POS > 1) ? $clog2(NUM_POS) : 1;
  localparam logic [POS_W-1:0] POS_TOP = POS_W'(NUM_POS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [RAD_W-1:0]     rem_r, rem_nxt;
  logic [ROOT_W-1:0]    root_r, root_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [WGT_W-1:0]     wgt_r, wgt_nxt;
  logic [TACC_W-1:0]    tacc_r, tacc_nxt;
  logic [3:0]           dig_r, dig_nxt;
  logic                 pv_r, pv_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [TERM_W-1:0]    pt_r, pt_nxt;
  logic                 pbig_r, pbig_nxt;
  logic                 plast_r, plast_nxt;
  logic [TERM_W-1:0]    best_t_r, best_t_nxt;
  logic [RAD_W-1:0]     best_term_r, best_term_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ROOT_W-1:0]    out_root_r, out_root_nxt;
  logic [RAD_W-1:0]     out_rem_r, out_rem_nxt;

  logic                 fits;
  logic                 digit_end;
  logic [TERM_W-1:0]    sel_t;
  logic [RAD_W-1:0]     sel_term;
  logic [SUM_W-1:0]     mul_a;
  logic [PROD_W-1:0]    mul_p;
  logic [WGT_W-1:0]     wgt_top;
  logic [WGT_W-1:0]     wgt_down;

  // Shared multiplier: (2*root + t) * t on the trial being issued.
  assign mul_a = {1'b0, root_r, 1'b0} + SUM_W'(tacc_r[TERM_W-1:0]);
  assign mul_p = PROD_W'(mul_a) * PROD_W'(tacc_r[TERM_W-1:0]);

  // Compare stage on the registered product of the previous trial.
  assign fits      = pv_r && !pbig_r && (prod_r <= PROD_W'(rem_r));
  assign digit_end = pv_r && (!fits || plast_r);
  assign sel_t     = fits ? pt_r : best_t_r;
  assign sel_term  = fits ? prod_r[RAD_W-1:0] : best_term_r;

  // Weights of the first position and of the next lower one.
  assign wgt_top  = pow10_cap(POW_IDX_W'(POS_TOP));
  assign wgt_down = pow10_cap(POW_IDX_W'(pos_r - POS_W'(1)));

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    pos_nxt       = pos_r;
    wgt_nxt       = wgt_r;
    tacc_nxt      = tacc_r;
    dig_nxt       = dig_r;
    pv_nxt        = pv_r;
    prod_nxt      = prod_r;
    pt_nxt        = pt_r;
    pbig_nxt      = pbig_r;
    plast_nxt     = plast_r;
    best_t_nxt    = best_t_r;
    best_term_nxt = best_term_r;
    out_valid_nxt = out_valid_r;
    out_root_nxt  = out_root_r;
    out_rem_nxt   = out_rem_r;

    // The output register empties when its item is taken.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rem_nxt       = in_radicand;
          root_nxt      = '0;
          pos_nxt       = POS_TOP;
          wgt_nxt       = wgt_top;
          tacc_nxt      = TACC_W'(wgt_top);
          dig_nxt       = 4'd1;
          pv_nxt        = 1'b0;
          best_t_nxt    = '0;
          best_term_nxt = '0;
          state_nxt     = ST_RUN;
        end
      end

      ST_RUN: begin
        // Remember the largest trial that still fits.
        if (fits) begin
          best_t_nxt    = pt_r;
          best_term_nxt = prod_r[RAD_W-1:0];
        end
        if (digit_end) begin
          // Commit the digit and move to the next lower position, or finish after the last.
          rem_nxt  = rem_r - sel_term;
          root_nxt = root_r + ROOT_W'(sel_t);
          pv_nxt   = 1'b0;
          if (pos_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            pos_nxt       = pos_r - POS_W'(1);
            wgt_nxt       = wgt_down;
            tacc_nxt      = TACC_W'(wgt_down);
            dig_nxt       = 4'd1;
            best_t_nxt    = '0;
            best_term_nxt = '0;
          end
        end else if (dig_r != 4'd0) begin
          // Issue the next trial digit while the last one is compared.
          prod_nxt  = mul_p;
          pt_nxt    = tacc_r[TERM_W-1:0];
          pbig_nxt  = (tacc_r[TACC_W-1:TERM_W] != '0);
          plast_nxt = (dig_r == DIGIT_MAX);
          pv_nxt    = 1'b1;
          tacc_nxt  = tacc_r + TACC_W'(wgt_r);
          dig_nxt   = (dig_r == DIGIT_MAX) ? 4'd0 : dig_r + 4'd1;
        end else begin
          pv_nxt = 1'b0;
        end
      end

      ST_DONE: begin
        // Move the result out once the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_root_nxt  = root_r;
          out_rem_nxt   = rem_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, datapath and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pv_r        <= 1'b0;
      dig_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      dig_r       <= dig_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r       <= rem_nxt;
    root_r      <= root_nxt;
    pos_r       <= pos_nxt;
    wgt_r       <= wgt_nxt;
    tacc_r      <= tacc_nxt;
    prod_r      <= prod_nxt;
    pt_r        <= pt_nxt;
    pbig_r      <= pbig_nxt;
    plast_r     <= plast_nxt;
    best_t_r    <= best_t_nxt;
    best_term_r <= best_term_nxt;
    out_root_r  <= out_root_nxt;
    out_rem_r   <= out_rem_nxt;
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_root      = out_root_r;
  assign out_remainder = out_rem_r;

  // A committed term never exceeds the remainder it is taken from.
  a_term_le_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && digit_end) |-> (PROD_W'(sel_term) <= PROD_W'(rem_r)))
    else $error("committed term exceeds remainder");

  // The trial digit counter stays within one to nine, or zero when spent.
  a_dig_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (dig_r <= DIGIT_MAX))
    else $error("trial digit out of range");

  // An accepted item starts a search and cannot produce a result at once.
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_RUN && !$rose(out_valid)))
    else $error("accepted item did not start a search");

  // A trial in the compare stage was issued in the run state.
  a_pv_run: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> $past(state_r == ST_RUN))
    else $error("trial in compare stage outside a search");

endmodule : decimal_digit_square_root_core

`default_nettype wire

// ===== bench/decimal_digit_square_root_core_test.sv =====
// Testbench for decimal_digit_square_root_core: it drives radicand items and checks
// every root and remainder against a digit-by-digit predictor held in the bench.
// Depends on dds_pkg and the core RTL.
`timescale 1ns / 1ps

module decimal_digit_square_root_core_test
  import dds_pkg::*;
();

  localparam int unsigned INT_DIGITS  = 4;
  localparam int unsigned FRAC_DIGITS = 4;
  localparam int unsigned ROOT_DIGITS = INT_DIGITS + FRAC_DIGITS;

  // Largest radicand in the nominal range and the saturated root.
  localparam logic [63:0] RAD_MAX   = 64'd9999999999999999;
  localparam logic [63:0] ROOT_NINES = 64'd99999999;
  localparam logic [63:0] TERM_CAP  = 64'd1 << TERM_W;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned SETTLE_CYCLES = 120;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  remainder;
  } sqrt_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [RAD_W-1:0] in_radicand;
  logic out_valid;
  logic out_stall;
  logic [ROOT_W-1:0] out_root;
  logic [RAD_W-1:0] out_remainder;

  sqrt_result_t pending_roots[$];
  int unsigned mismatch_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned out_stall_pct = 0;

  decimal_digit_square_root_core #(
    .INT_DIGITS (INT_DIGITS),
    .FRAC_DIGITS(FRAC_DIGITS)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_radicand  (in_radicand),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_root     (out_root),
    .out_remainder(out_remainder)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Long-hand decimal square root: at each digit weight, keep the largest
  // digit whose term (2*root + t)*t still fits in the remainder.
  function automatic sqrt_result_t predict_sqrt(input logic [RAD_W-1:0] radicand);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] weight;
    logic [63:0] trial;
    logic [63:0] prod;
    logic [63:0] best_t;
    logic [63:0] best_prod;
    sqrt_result_t res;
    rem = 64'(radicand);
    root = 64'd0;
    weight = 64'd1;
    for (int i = 1; i < ROOT_DIGITS; i++) weight = weight * 10;
    for (int pos = ROOT_DIGITS - 1; pos >= 0; pos--) begin
      best_t = 64'd0;
      best_prod = 64'd0;
      for (int d = 1; d <= 9; d++) begin
        trial = 64'(d) * weight;
        // A weight this large squares past any remainder.
        if (trial >= TERM_CAP) break;
        prod = (2 * root + trial) * trial;
        if (prod > rem) break;
        best_t = trial;
        best_prod = prod;
      end
      rem = rem - best_prod;
      root = root + best_t;
      weight = weight / 10;
    end
    res.root = root[ROOT_W-1:0];
    res.remainder = rem[RAD_W-1:0];
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] ten_to(input int unsigned n);
    logic [63:0] v;
    v = 64'd1;
    for (int i = 0; i < n; i++) v = v * 10;
    return v;
  endfunction

  // A square, or a value right next to one, clipped to the nominal range.
  function automatic logic [RAD_W-1:0] square_near(input logic [63:0] r);
    logic [63:0] v;
    v = r * r;
    case ($urandom_range(0, 3))
      0: v = v;
      1: if (r != 0) v = v - 1;
      2: v = v + 1;
      default: v = v + 2 * r;
    endcase
    if (v > RAD_MAX) v = RAD_MAX;
    return v[RAD_W-1:0];
  endfunction

  // Send one item: maybe idle first, then hold valid until it is accepted.
  // Valid stays high on return so back-to-back items need no toggle.
  task automatic send_radicand(input logic [RAD_W-1:0] value);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_radicand <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_roots.push_back(predict_sqrt(value));
  endtask

  // Check each accepted result and draw the next stall decision.
  always @(posedge clk) begin
    sqrt_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_roots.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: root %0d remainder %0d", out_root, out_remainder);
      end else begin
        want = pending_roots.pop_front();
        if (out_root !== want.root || out_remainder !== want.remainder) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: root %0d (expected %0d), remainder %0d (expected %0d)",
                     out_root, want.root, out_remainder, want.remainder);
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  // Corners: zero, tiny values, powers of ten, bit patterns, saturation.
  task automatic test_directed_corners();
    logic [63:0] corners[$];
    corners = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd8, 64'd9, 64'd99, 64'd100,
                64'd99999999, 64'd100000000, 64'd1000000000000000,
                64'd123456789012345, 64'h15555555555555, 64'h0AAAAAAAAAAAAA,
                (64'd1 << 53) - 1, 64'd1 << 53,
                ROOT_NINES * ROOT_NINES - 1, ROOT_NINES * ROOT_NINES, RAD_MAX,
                64'd10000000000000000, (64'd1 << RAD_W) - 1};
    foreach (corners[i]) send_radicand(corners[i][RAD_W-1:0]);
  endtask

  // Squares and their neighbors, with roots of every digit count.
  task automatic test_perfect_squares(input int unsigned count);
    logic [63:0] r;
    repeat (count) begin
      r = rand64() % ten_to($urandom_range(1, ROOT_DIGITS));
      send_radicand(square_near(r));
    end
  endtask

  // Radicands on both sides of the point where the root turns all nines.
  task automatic test_saturation(input int unsigned count);
    logic [63:0] v;
    repeat (count) begin
      if ($urandom_range(0, 1) == 0)
        v = ROOT_NINES * ROOT_NINES + $urandom_range(0, 199999998);
      else
        v = ROOT_NINES * ROOT_NINES - 1 - $urandom_range(0, 400000000);
      send_radicand(v[RAD_W-1:0]);
    end
  endtask

  // A mix of magnitudes: uniform, small, random digit lengths, squares, near maximum.
  task automatic test_random_radicands(input int unsigned count);
    logic [63:0] v;
    repeat (count) begin
      case ($urandom_range(0, 4))
        0: v = rand64() % (RAD_MAX + 1);
        1: v = $urandom_range(0, 1000000);
        2: v = rand64() % ten_to($urandom_range(1, 16));
        3: v = 64'(square_near(rand64() % ten_to($urandom_range(1, ROOT_DIGITS))));
        default: v = RAD_MAX - $urandom_range(0, 1000000);
      endcase
      send_radicand(v[RAD_W-1:0]);
    end
  endtask

  // Let the core drain completely before sending again.
  task automatic test_drain_pause(input int unsigned count);
    in_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    test_random_radicands(count);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_radicand <= '0;
    out_stall <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Phase 1: no idling on either side.
    test_directed_corners();
    test_perfect_squares(90);
    test_saturation(40);
    test_random_radicands(130);

    // Phase 2: sender idles about half the time.
    send_gap_pct = 49;
    test_perfect_squares(90);
    test_saturation(40);
    test_random_radicands(130);

    // Phase 3: receiver stalls about half the time.
    send_gap_pct = 0;
    out_stall_pct = 49;
    test_perfect_squares(90);
    test_saturation(40);
    test_drain_pause(130);

    // Phase 4: both sides idle now and then.
    send_gap_pct = 18;
    out_stall_pct = 18;
    test_perfect_squares(90);
    test_saturation(40);
    test_random_radicands(130);

    // Wait for the last results, then a little longer for stragglers.
    in_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_roots.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
